// ===== hw/rtl/xxc_pkg.sv =====
// ----------------------------------------------------------------------------
// xxc_pkg
// Types, codes and character mapping functions shared by the xx codec.
// ----------------------------------------------------------------------------
package xxc_pkg;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // bytes per group when encoding, characters per group when decoding
   localparam int ENC_GROUP = 3;
   localparam int DEC_GROUP = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_item;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // one flushed group: up to four result words, first word in entry 0
   typedef struct packed {
      logic [3:0][7:0] byte_list;
      logic [2:0]      count;
      logic            last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // 6-bit symbol to its character in "+-0-9A-Za-z"
   function automatic logic [7:0] xx_char(input logic [5:0] sym);
      logic [7:0] s;
      s = {2'b00, sym};
      if (sym == 6'd0) begin
         return 8'h2b;                     // '+'
      end else if (sym == 6'd1) begin
         return 8'h2d;                     // '-'
      end else if (sym < 6'd12) begin
         return s + 8'd46;                 // '0' - 2
      end else if (sym < 6'd38) begin
         return s + 8'd53;                 // 'A' - 12
      end else begin
         return s + 8'd59;                 // 'a' - 38
      end
   endfunction

   // 7-bit character to its 6-bit value, anything outside the alphabet is 0
   function automatic logic [5:0] xx_value(input logic [6:0] ch);
      logic [6:0] v;
      v = 7'd0;
      if (ch == 7'h2b) begin
         v = 7'd0;
      end else if (ch == 7'h2d) begin
         v = 7'd1;
      end else if (ch >= 7'h30 && ch <= 7'h39) begin
         v = ch - 7'd46;
      end else if (ch >= 7'h41 && ch <= 7'h5a) begin
         v = ch - 7'd53;
      end else if (ch >= 7'h61 && ch <= 7'h7a) begin
         v = ch - 7'd59;
      end
      return v[5:0];
   endfunction

endpackage

// ===== hw/rtl/xxencode_codec_unit.sv =====
// ----------------------------------------------------------------------------
// xxencode_codec_unit
// Streaming xxencode / xxdecode of a message body, no line headers.
// ----------------------------------------------------------------------------
// Mode 0 packs every three input bytes into four characters of the xx
// alphabet; mode 1 packs every four characters (bit 7 ignored, unknown
// characters read as 0) into three bytes. last_item flushes a short group:
// encode always gives four characters, a decode group of k characters gives
// k-1 bytes. An input word is taken every cycle while the job queue
// (QUEUE_DEPTH groups) has room; the back end sends one result word per
// cycle while rsp_stall is low, so encode, with four results per three
// input words, is held by the output and decode is one word per cycle. A
// closing word passes the job queue, job register and output register.
// Write mode only while the unit is idle; a write drops any partial group.
module xxencode_codec_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data,
   input  logic             req_valid,
   input  xxc_pkg::req_type req_payload,
   output logic             req_stall,
   output logic             rsp_valid,
   output xxc_pkg::rsp_type rsp_payload,
   input  logic             rsp_stall
);
   import xxc_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             job_push;
   logic             job_pop;

   assign csr_ready = 1'b1;

   xxc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_status    (q_status),
      .job_push    (job_push),
      .job         (push_job)
   );

   xxc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   xxc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .pop         (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

`ifndef SYNTHESIS
   // queue overflow
   assert property (@(posedge clock) disable iff (reset)
      !(job_push && q_status.full))
      else $error("job pushed into full queue");

   // queue underflow
   assert property (@(posedge clock) disable iff (reset)
      !(job_pop && q_status.empty))
      else $error("job popped from empty queue");

   // a job that is pushed always carries at least one word
   assert property (@(posedge clock) disable iff (reset)
      job_push |-> (push_job.count != 3'd0))
      else $error("empty job queued");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid after reset");
`endif

endmodule

// ===== hw/rtl/xxc_front.sv =====
// ----------------------------------------------------------------------------
// xxc_front
// Takes input words, gathers them into groups and turns each finished group
// into a job of up to four result words for the back end.
// ----------------------------------------------------------------------------
module xxc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic                      csr_data,
   input  logic                      req_valid,
   input  xxc_pkg::req_type          req_payload,
   output logic                      req_stall,
   input  xxc_pkg::queue_status_type q_status,
   output logic                      job_push,
   output xxc_pkg::job_type          job
);
   import xxc_pkg::*;

   logic        mode_ff, mode_in;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  count_ff, count_in;

   logic        accept;
   logic        emit;
   logic [2:0]  k;
   logic [5:0]  dec_val;
   logic [23:0] enc_full, dec_full;
   logic [23:0] enc_bits, dec_bits;

   always_comb begin
      req_stall = q_status.full;
      accept    = req_valid && !q_status.full;
      k         = {1'b0, count_ff} + 3'd1;
      dec_val   = xx_value(req_payload.data_byte[6:0]);
      enc_full  = {bits_ff[15:0], req_payload.data_byte};
      dec_full  = {bits_ff[17:0], dec_val};

      // left align a short group, zero fill below
      case (count_ff)
         2'd0: begin
            enc_bits = enc_full << 16;
            dec_bits = dec_full << 18;
         end
         2'd1: begin
            enc_bits = enc_full << 8;
            dec_bits = dec_full << 12;
         end
         2'd2: begin
            enc_bits = enc_full;
            dec_bits = dec_full << 6;
         end
         default: begin
            enc_bits = enc_full;
            dec_bits = dec_full;
         end
      endcase

      if (mode_ff == MODE_ENCODE) begin
         emit              = req_payload.last_item || (k == 3'(ENC_GROUP));
         job.byte_list[0]  = xx_char(enc_bits[23:18]);
         job.byte_list[1]  = xx_char(enc_bits[17:12]);
         job.byte_list[2]  = xx_char(enc_bits[11:6]);
         job.byte_list[3]  = xx_char(enc_bits[5:0]);
         job.count         = 3'd4;
      end else begin
         emit              = req_payload.last_item || (k == 3'(DEC_GROUP));
         job.byte_list[0]  = dec_bits[23:16];
         job.byte_list[1]  = dec_bits[15:8];
         job.byte_list[2]  = dec_bits[7:0];
         job.byte_list[3]  = 8'h00;
         job.count         = k - 3'd1;
      end
      job.last = req_payload.last_item;

      // a lone final decode character gives nothing
      job_push = accept && emit && (job.count != 3'd0);

      mode_in  = mode_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      if (csr_valid) begin
         mode_in  = csr_data;
         bits_in  = 24'd0;
         count_in = 2'd0;
      end else if (accept) begin
         if (emit) begin
            bits_in  = 24'd0;
            count_in = 2'd0;
         end else begin
            bits_in  = (mode_ff == MODE_ENCODE) ? enc_full : dec_full;
            count_in = k[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         bits_ff  <= 24'd0;
         count_ff <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/xxc_queue.sv =====
// ----------------------------------------------------------------------------
// xxc_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module xxc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  xxc_pkg::job_type          push_job,
   input  logic                      pop,
   output xxc_pkg::job_type          head_job,
   output xxc_pkg::queue_status_type status
);
   import xxc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == CNT_W'(DEPTH));
      status.empty = (count_ff == '0);
      head_job     = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/xxc_back.sv =====
// ----------------------------------------------------------------------------
// xxc_back
// Takes jobs from the queue and sends their result words one per cycle
// while rsp_stall is low, through the output register.
// ----------------------------------------------------------------------------
module xxc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  xxc_pkg::job_type          head_job,
   input  xxc_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   output xxc_pkg::rsp_type          rsp_payload,
   input  logic                      rsp_stall
);
   import xxc_pkg::*;

   logic       active_ff, active_in;
   job_type    job_ff, job_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       out_free;
   logic       at_end;
   logic       finishing;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      at_end    = ({1'b0, idx_ff} == (job_ff.count - 3'd1));
      finishing = active_ff && out_free && at_end;
      pop       = !q_status.empty && (!active_ff || finishing);

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = active_ff;
         rsp_in.out_byte = job_ff.byte_list[idx_ff];
         rsp_in.out_last = job_ff.last && at_end;
      end

      active_in = active_ff;
      job_in    = job_ff;
      idx_in    = idx_ff;
      if (pop) begin
         active_in = 1'b1;
         job_in    = head_job;
         idx_in    = 2'd0;
      end else if (active_ff && out_free) begin
         active_in = !at_end;
         idx_in    = idx_ff + 2'd1;
      end

      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_ff;
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
